@@ hw/rtl/mhic_pkg.sv @@
`default_nettype none

package mhic_pkg;

    // Sizes fixed by the sensor byte layout and the register map.
    localparam int AXES         = 3;
    localparam int SAMPLE_W     = 16;
    localparam int SENS_W       = 9;
    localparam int LIMIT_W      = 15;
    localparam int MASK_W       = 8;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 15;
    localparam int IN_DATA_W    = 64;
    localparam int OUT_DATA_W   = 96;
    localparam int OUT_USER_W   = 2;

    // Default moving-average depth and depth of the front-to-back queue.
    localparam int WINDOW_DEPTH_DEF = 4;
    localparam int QUEUE_DEPTH      = 4;

    // Reset values of the configuration registers.
    localparam logic [SENS_W-1:0]  SENS_RESET     = SENS_W'(256);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET    = LIMIT_W'(1000);
    localparam logic [MASK_W-1:0]  READY_RESET    = MASK_W'(1);
    localparam logic [MASK_W-1:0]  OVERRUN_RESET  = MASK_W'(2);
    localparam logic [MASK_W-1:0]  OVERFLOW_RESET = MASK_W'(8);

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SENS_X        = 3'd0,
        CFG_SENS_Y        = 3'd1,
        CFG_SENS_Z        = 3'd2,
        CFG_REJECT_LIMIT  = 3'd3,
        CFG_READY_MASK    = 3'd4,
        CFG_OVERRUN_MASK  = 3'd5,
        CFG_OVERFLOW_MASK = 3'd6
    } cfg_index_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // One classified sample as it travels from the front to the back.
    typedef struct packed {
        logic                   accept;
        sample_t [AXES-1:0]     scaled;
    } item_t;

    // Result flags as carried on the output tuser, fresh in the lowest bit.
    typedef struct packed {
        logic calib_changed;
        logic fresh;
    } result_flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/mhic_front.sv @@
`default_nettype none

module mhic_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [mhic_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mhic_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic [mhic_pkg::IN_DATA_W-1:0]   in_data,
    output mhic_pkg::item_t                       item
);
    import mhic_pkg::*;

    localparam int SCALE_PROD_W = SAMPLE_W + SENS_W + 1;

    logic [SENS_W-1:0]  sens_reg [AXES];
    logic [LIMIT_W-1:0] limit_reg;
    logic [MASK_W-1:0]  ready_mask_reg;
    logic [MASK_W-1:0]  overrun_mask_reg;
    logic [MASK_W-1:0]  overflow_mask_reg;

    logic [MASK_W-1:0]  status_one;
    logic [MASK_W-1:0]  status_two;
    logic               status_ok;
    logic [AXES-1:0]    axis_ok;
    logic signed [SAMPLE_W:0] limit_pos;
    logic signed [SAMPLE_W:0] limit_neg;

    // Configuration registers; the user must write them only while the block is idle, which is not enforced here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg[0]       <= SENS_RESET;
            sens_reg[1]       <= SENS_RESET;
            sens_reg[2]       <= SENS_RESET;
            limit_reg         <= LIMIT_RESET;
            ready_mask_reg    <= READY_RESET;
            overrun_mask_reg  <= OVERRUN_RESET;
            overflow_mask_reg <= OVERFLOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SENS_X:        sens_reg[0]       <= cfg_wdata[SENS_W-1:0];
                CFG_SENS_Y:        sens_reg[1]       <= cfg_wdata[SENS_W-1:0];
                CFG_SENS_Z:        sens_reg[2]       <= cfg_wdata[SENS_W-1:0];
                CFG_REJECT_LIMIT:  limit_reg         <= cfg_wdata[LIMIT_W-1:0];
                CFG_READY_MASK:    ready_mask_reg    <= cfg_wdata[MASK_W-1:0];
                CFG_OVERRUN_MASK:  overrun_mask_reg  <= cfg_wdata[MASK_W-1:0];
                CFG_OVERFLOW_MASK: overflow_mask_reg <= cfg_wdata[MASK_W-1:0];
                default:           ;
            endcase
        end
    end

    // Status bytes sit at both ends of the eight-byte burst.
    assign status_one = in_data[MASK_W-1:0];
    assign status_two = in_data[IN_DATA_W-1 -: MASK_W];
    assign status_ok  = ((status_one & ready_mask_reg) != '0) &&
                        ((status_one & overrun_mask_reg) == '0) &&
                        ((status_two & overflow_mask_reg) == '0);

    assign limit_pos = $signed({2'b00, limit_reg});
    assign limit_neg = -limit_pos;

    // Per-axis scaling: raw times factor, floor shift by 8, wrap to 16 bits.
    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        logic signed [SAMPLE_W-1:0]          raw;
        logic signed [SCALE_PROD_W-1:0]      prod;
        logic signed [SAMPLE_W:0]            scaled_ext;

        assign raw        = $signed(in_data[MASK_W + SAMPLE_W*a +: SAMPLE_W]);
        assign prod       = SCALE_PROD_W'(raw) *
                            SCALE_PROD_W'($signed({1'b0, sens_reg[a]}));
        assign item.scaled[a] = prod[SAMPLE_W+7:8];
        assign scaled_ext = {prod[SAMPLE_W+7], prod[SAMPLE_W+7:8]};
        assign axis_ok[a] = (scaled_ext <= limit_pos) && (scaled_ext >= limit_neg);
    end

    assign item.accept = status_ok && (&axis_ok);

endmodule

`default_nettype wire

@@ hw/rtl/mhic_fifo.sv @@
`default_nettype none

module mhic_fifo (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  mhic_pkg::item_t in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output mhic_pkg::item_t out_item
);
    import mhic_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entry_reg[rd_ptr_reg];

    // Queue entries hold payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mhic_back.sv @@
`default_nettype none

module mhic_back #(
    parameter int WINDOW_DEPTH = mhic_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  mhic_pkg::item_t                      in_item,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [mhic_pkg::OUT_DATA_W-1:0]      out_data,
    output logic [mhic_pkg::OUT_USER_W-1:0]      out_user
);
    import mhic_pkg::*;

    // The window sum grows by log2 of the depth; its magnitude needs one bit less.
    localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int MAG_W       = SUM_W - 1;
    // Division by the depth is a multiply by a rounded-up reciprocal, exact
    // for every window sum of accepted samples at depths from 2 up to 22.
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = MAG_W + RECIP_SHIFT;
    localparam logic [RECIP_SHIFT-1:0] RECIP =
        RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);

    logic                    advance;
    logic                    take;

    sample_t                 window_reg [WINDOW_DEPTH][AXES];
    logic signed [SUM_W-1:0] sum_reg [AXES];
    logic signed [SUM_W-1:0] sum_next [AXES];

    logic                    s1_valid_reg;
    logic                    s1_accept_reg;
    logic                    s2_valid_reg;
    logic                    s2_accept_reg;
    logic [AXES-1:0]         s2_neg_reg;
    logic [PROD_W-1:0]       s2_prod_reg [AXES];
    logic                    s3_valid_reg;
    logic                    s3_accept_reg;
    sample_t                 s3_avg_reg [AXES];
    logic                    s4_valid_reg;
    logic                    s4_accept_reg;
    logic                    s4_changed_reg;
    sample_t                 s4_avg_reg [AXES];

    sample_t                 max_reg [AXES];
    sample_t                 min_reg [AXES];
    sample_t                 held_reg [AXES];
    logic [AXES-1:0]         grow_max;
    logic [AXES-1:0]         grow_min;

    logic [MAG_W-1:0]        mag [AXES];
    sample_t                 quot [AXES];
    sample_t                 bias [AXES];
    sample_t                 corr [AXES];
    sample_t                 res [AXES];

    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    result_flags_t           out_flags_reg;

    // All stages move together whenever the output register is free.
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign take      = in_valid && advance && in_item.accept;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_flags_reg;

    // Running window sum: add the newest sample, drop the oldest.
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            sum_next[a] = sum_reg[a]
                + {{(SUM_W-SAMPLE_W){in_item.scaled[a][SAMPLE_W-1]}}, in_item.scaled[a]}
                - {{(SUM_W-SAMPLE_W){window_reg[0][a][SAMPLE_W-1]}}, window_reg[0][a]};
        end
    end

    // Window shift line and sum; these are the stage-one payload as well.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW_DEPTH; k++)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    window_reg[k][a] <= '0;
                end
            end
            for (int a = 0; a < AXES; a++)
            begin
                sum_reg[a] <= '0;
            end
        end
        else if (take)
        begin
            for (int k = 0; k < WINDOW_DEPTH - 1; k++)
            begin
                window_reg[k] <= window_reg[k+1];
            end
            for (int a = 0; a < AXES; a++)
            begin
                window_reg[WINDOW_DEPTH-1][a] <= in_item.scaled[a];
                sum_reg[a]                    <= sum_next[a];
            end
        end
    end

    // Magnitude of each sum for the reciprocal multiply.
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            mag[a] = sum_reg[a][SUM_W-1] ? MAG_W'(-sum_reg[a]) : MAG_W'(sum_reg[a]);
        end
    end

    // Quotient with the sign put back: truncation toward zero.
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            quot[a] = s2_prod_reg[a][RECIP_SHIFT +: SAMPLE_W];
            if (s2_neg_reg[a])
            begin
                quot[a] = -quot[a];
            end
        end
    end

    // Extremes move outward only.
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            grow_max[a] = (s3_avg_reg[a] > max_reg[a]);
            grow_min[a] = (s3_avg_reg[a] < min_reg[a]);
        end
    end

    // Midpoint bias, correction and axis remap. Min never exceeds max here,
    // since both start at zero and only move outward, so the bias always
    // equals the halved sum of the current extremes.
    always_comb
    begin
        logic signed [SAMPLE_W:0] mid;
        logic signed [SAMPLE_W:0] mid_adj;
        for (int a = 0; a < AXES; a++)
        begin
            mid     = {max_reg[a][SAMPLE_W-1], max_reg[a]} +
                      {min_reg[a][SAMPLE_W-1], min_reg[a]};
            mid_adj = mid + {{SAMPLE_W{1'b0}}, mid[SAMPLE_W]};
            bias[a] = mid_adj[SAMPLE_W:1];
            corr[a] = s4_avg_reg[a] - bias[a];
        end
        if (s4_accept_reg)
        begin
            res[0] = corr[2];
            res[1] = -corr[0];
            res[2] = -corr[1];
        end
        else
        begin
            res[0] = held_reg[0];
            res[1] = held_reg[1];
            res[2] = held_reg[2];
        end
    end

    // Pipeline control bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_accept_reg  <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_accept_reg  <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s3_accept_reg  <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s4_accept_reg  <= 1'b0;
            s4_changed_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg   <= in_valid;
            s1_accept_reg  <= in_item.accept;
            s2_valid_reg   <= s1_valid_reg;
            s2_accept_reg  <= s1_accept_reg;
            s3_valid_reg   <= s2_valid_reg;
            s3_accept_reg  <= s2_accept_reg;
            s4_valid_reg   <= s3_valid_reg;
            s4_accept_reg  <= s3_accept_reg;
            s4_changed_reg <= s3_accept_reg && ((grow_max | grow_min) != '0);
            out_valid_reg  <= s4_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                s2_neg_reg[a]  <= sum_reg[a][SUM_W-1];
                s2_prod_reg[a] <= PROD_W'(mag[a]) * PROD_W'(RECIP);
                s3_avg_reg[a]  <= quot[a];
                s4_avg_reg[a]  <= s3_avg_reg[a];
            end
            out_data_reg          <= {bias[2], bias[1], bias[0], res[2], res[1], res[0]};
            out_flags_reg.fresh         <= s4_accept_reg;
            out_flags_reg.calib_changed <= s4_changed_reg;
        end
    end

    // Calibration extremes and the held output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                max_reg[a]  <= '0;
                min_reg[a]  <= '0;
                held_reg[a] <= sample_t'(1);
            end
        end
        else if (advance)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                if (s3_valid_reg && s3_accept_reg && grow_max[a])
                begin
                    max_reg[a] <= s3_avg_reg[a];
                end
                if (s3_valid_reg && s3_accept_reg && grow_min[a])
                begin
                    min_reg[a] <= s3_avg_reg[a];
                end
                if (s4_valid_reg && s4_accept_reg)
                begin
                    held_reg[a] <= res[a];
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/magnetometer_hard_iron_conditioner.sv @@
// Hard-iron conditioner for a three-axis magnetometer.
// Input channel s_*: one item is one eight-byte sensor burst (status one,
// X, Y and Z little-endian, status two). Configuration is a plain write
// port (cfg_we, cfg_index, cfg_wdata); the user must use it only while
// the block is idle; the block does not enforce it. Output channel m_*:
// exactly one result item per input item, in order: the bias-corrected,
// remapped axes, the current bias, and the flags fresh (sample accepted)
// and calib_changed (an extreme moved; persist it). Throughput is one
// item per cycle when the output is not stalled. The classifier in front
// writes a four-entry queue; the back end is a five-register pipeline
// (window sum, reciprocal multiply, sign restore, min/max update, bias and
// output register). The window-sum and min/max update loops set the
// one-item-per-cycle rate. When m_tready is low with a result waiting,
// the whole back pipeline holds and the queue fills; s_tready drops once
// the queue is full. Nothing is lost or repeated. Reset clears the
// window, sum and extremes to zero, sets the held output to one on each
// axis and loads the default configuration.
`default_nettype none

module magnetometer_hard_iron_conditioner #(
    parameter int WINDOW_DEPTH = mhic_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [mhic_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mhic_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0 up: status_one, x_low, x_high, y_low, y_high,
    // z_low, z_high, status_two.
    input  wire logic [mhic_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // Fields from bit 0 up: out_x, out_y, out_z, bias_x, bias_y, bias_z.
    output logic [mhic_pkg::OUT_DATA_W-1:0]       m_tdata,
    // Fields from bit 0 up: fresh, calib_changed.
    output logic [mhic_pkg::OUT_USER_W-1:0]       m_tuser
);
    import mhic_pkg::*;

    item_t front_item;
    item_t queue_item;
    logic  queue_valid;
    logic  back_ready;

    // Front: configuration, scaling and accept decision.
    mhic_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .item      (front_item)
    );

    // Queue between the classifier and the back pipeline.
    mhic_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (back_ready),
        .out_item  (queue_item)
    );

    // Back: averaging, calibration and output.
    mhic_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_ready  (back_ready),
        .in_item   (queue_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

`default_nettype wire

@@ hw/rtl/mhic_checker.sv @@
`default_nettype none

module mhic_assertions (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [mhic_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  wire logic [mhic_pkg::OUT_USER_W-1:0]  m_tuser
);
    import mhic_pkg::*;

    localparam int BIAS_LO = AXES * SAMPLE_W;

    logic [OUT_DATA_W-1:0] last_data_reg;
    result_flags_t         flags;

    assign flags = m_tuser;

    // Last delivered result; before any, the reset held output and zero bias.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_data_reg <= {{(AXES*SAMPLE_W){1'b0}},
                              SAMPLE_W'(1), SAMPLE_W'(1), SAMPLE_W'(1)};
        end
        else if (m_tvalid && m_tready)
        begin
            last_data_reg <= m_tdata;
        end
    end

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Calibration can only move on an accepted sample.
    a_change_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && flags.calib_changed |-> flags.fresh)
        else $error("calib_changed on a refused sample");

    // A refused sample repeats the previous result exactly.
    a_refused_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !flags.fresh |-> m_tdata == last_data_reg)
        else $error("refused sample does not repeat the held result");

    // The bias moves only when the calibration changed.
    a_bias_steady: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !flags.calib_changed |->
            m_tdata[OUT_DATA_W-1:BIAS_LO] == last_data_reg[OUT_DATA_W-1:BIAS_LO])
        else $error("bias moved without a calibration change");

endmodule

bind magnetometer_hard_iron_conditioner mhic_assertions u_mhic_assertions (.*);

`default_nettype wire
